// ===== sv/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the mailbox channel register block.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // register offsets within the 256-byte window
  localparam logic [7:0] ADDR_CTRL    = 8'h00;
  localparam logic [7:0] ADDR_STATUS  = 8'h04;
  localparam logic [7:0] ADDR_TXSIZE  = 8'h08;
  localparam logic [7:0] ADDR_TXDATA  = 8'h0C;
  localparam logic [7:0] ADDR_RXSIZE  = 8'h10;
  localparam logic [7:0] ADDR_RX_BASE = 8'h14;

  // request actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_HOST  = 2'd2;

  // control register bits
  localparam int unsigned CTRL_DI_BIT  = 0;
  localparam int unsigned CTRL_RST_BIT = 1;

  // width of a message byte count in the command queue
  localparam int unsigned CNT_W = 7;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_READ = 2'd1,
    KIND_TX   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    FLT_OK     = 3'd0,
    FLT_BUSY   = 3'd1,
    FLT_SIZE   = 3'd2,
    FLT_NOSIZE = 3'd3,
    FLT_ADDR   = 3'd4,
    FLT_OVFL   = 3'd5
  } fault_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  addr;
    logic [31:0] wdata;
    logic [7:0]  host_byte;
    logic        host_last;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] rdata;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        irq_level;
    fault_e      fault;
  } out_item_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    kind_e            kind;
    logic [31:0]      rdata;
    fault_e           fault;
    logic             irq;
    logic [CNT_W-1:0] count;
  } cmd_t;

  function automatic int unsigned addr_width(int unsigned depth);
    addr_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== sv/mailbox_channel_registers_unit.sv =====
// ----------------------------------------------------------------------------
// mailbox_channel_registers_unit
// Byte mailbox behind an 8-bit register window, queue-style request and
// result ports.
// ----------------------------------------------------------------------------
// Each request (bus write, bus read or host byte) gives one result, except a
// transmit data write that completes a message, which gives one transmitted
// byte result per message byte with a last mark on the final one. Requests
// are taken one per cycle while full is low; a result passes the decode and
// receive buffer read stage, the command queue and the result register
// before it can be popped. A completed message drains from the transmit
// memory at one byte per cycle through its single read port while the result
// register is free, and full stays high from the completing write until the
// last byte has been read out of that memory.
// Configuration is through the register window itself; no clearing pass is
// needed after reset (receive buffer entries carry valid bits).
module mailbox_channel_registers_unit #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 push,
  input  mcr_pkg::in_item_t    in_data_i,
  output logic                 full,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output mcr_pkg::out_item_t   out_data_o
);

  localparam int unsigned AW = mcr_pkg::addr_width(BUF_DEPTH);

  // front to queue
  logic          cmd_push;
  mcr_pkg::cmd_t cmd_in;
  logic          cmd_full;

  // queue to back
  logic          cmd_pop;
  mcr_pkg::cmd_t cmd_out;
  logic          cmd_empty;

  // transmit memory ports
  logic          tx_we;
  logic [AW-1:0] tx_waddr;
  logic [7:0]    tx_wdata;
  logic          tx_re;
  logic [AW-1:0] tx_raddr;
  logic [7:0]    tx_rdata;

  // back end finished reading the message out
  logic          flush_done;

  // decoder: registers, receive buffer and transmit fill
  mcr_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .item_i       (in_data_i),
    .full         (full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .cmd_full_i   (cmd_full),
    .tx_we_o      (tx_we),
    .tx_waddr_o   (tx_waddr),
    .tx_wdata_o   (tx_wdata),
    .flush_done_i (flush_done)
  );

  // decouples decoding from result back-pressure
  mcr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // transmit message storage, filled by the front, drained by the back
  mcr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  // result sequencer with the output register
  mcr_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .tx_re_o      (tx_re),
    .tx_raddr_o   (tx_raddr),
    .tx_rdata_i   (tx_rdata),
    .flush_done_o (flush_done),
    .empty        (empty),
    .pop          (pop),
    .out_o        (out_data_o)
  );

endmodule

// ===== sv/mcr_ram.sv =====
// ----------------------------------------------------------------------------
// mcr_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [mcr_pkg::addr_width(DEPTH)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [mcr_pkg::addr_width(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Request decoder: register file, receive buffer and transmit fill.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      push,
  input  mcr_pkg::in_item_t                         item_i,
  output logic                                      full,
  output logic                                      cmd_push_o,
  output mcr_pkg::cmd_t                             cmd_o,
  input  logic                                      cmd_full_i,
  output logic                                      tx_we_o,
  output logic [mcr_pkg::addr_width(BUF_DEPTH)-1:0] tx_waddr_o,
  output logic [7:0]                                tx_wdata_o,
  input  logic                                      flush_done_i
);

  localparam int unsigned LEN_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned AW    = mcr_pkg::addr_width(BUF_DEPTH);

  logic                 di_q, di_d;
  logic                 rdy_q, rdy_d;
  logic                 irq_q, irq_d;
  logic [LEN_W-1:0]     tx_len_q, tx_len_d;
  logic [LEN_W-1:0]     tx_fill_q, tx_fill_d;
  logic [LEN_W-1:0]     rx_len_q, rx_len_d;
  logic [LEN_W-1:0]     rx_fill_q, rx_fill_d;
  logic [BUF_DEPTH-1:0] rx_vld_q, rx_vld_d;
  logic                 flush_pend_q, flush_pend_d;
  logic                 s1_valid_q;
  mcr_pkg::cmd_t        s1_q;
  logic                 s1_rx_q;

  logic                 take;
  logic                 s1_adv;
  logic                 rx_we;
  logic                 rx_re;
  logic                 rx_hit;
  logic [7:0]           rx_off;
  logic [LEN_W-1:0]     tx_fill_inc;
  logic [7:0]           rx_rdata;
  mcr_pkg::cmd_t        ent;

  assign s1_adv = !s1_valid_q || !cmd_full_i;
  assign full   = flush_pend_q || !s1_adv;
  assign take   = push && !full;

  assign rx_off      = item_i.addr - mcr_pkg::ADDR_RX_BASE;
  assign tx_fill_inc = tx_fill_q + LEN_W'(1);

  assign tx_waddr_o = tx_fill_q[AW-1:0];
  assign tx_wdata_o = item_i.wdata[7:0];

  always_comb begin
    di_d         = di_q;
    rdy_d        = rdy_q;
    irq_d        = irq_q;
    tx_len_d     = tx_len_q;
    tx_fill_d    = tx_fill_q;
    rx_len_d     = rx_len_q;
    rx_fill_d    = rx_fill_q;
    rx_vld_d     = rx_vld_q;
    flush_pend_d = flush_pend_q;
    tx_we_o      = 1'b0;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    rx_hit       = 1'b0;
    ent          = '0;
    ent.kind     = mcr_pkg::KIND_ACK;
    ent.fault    = mcr_pkg::FLT_OK;

    if (flush_done_i) begin
      flush_pend_d = 1'b0;
    end

    if (take) begin
      unique case (item_i.action)
        mcr_pkg::ACT_WRITE: begin
          unique case (item_i.addr)
            mcr_pkg::ADDR_CTRL: begin
              di_d = item_i.wdata[mcr_pkg::CTRL_DI_BIT] &
                     !item_i.wdata[mcr_pkg::CTRL_RST_BIT];
              if (item_i.wdata[mcr_pkg::CTRL_DI_BIT]) begin
                irq_d = 1'b0;
              end
              if (item_i.wdata[mcr_pkg::CTRL_RST_BIT]) begin
                rdy_d     = 1'b0;
                tx_len_d  = '0;
                tx_fill_d = '0;
                rx_len_d  = '0;
              end
            end
            mcr_pkg::ADDR_TXSIZE: begin
              if (tx_len_q != '0) begin
                ent.fault = mcr_pkg::FLT_BUSY;
              end
              if (item_i.wdata > 32'(BUF_DEPTH)) begin
                ent.fault = mcr_pkg::FLT_SIZE;
                tx_len_d  = LEN_W'(BUF_DEPTH);
              end else begin
                tx_len_d  = item_i.wdata[LEN_W-1:0];
              end
              tx_fill_d = '0;
            end
            mcr_pkg::ADDR_TXDATA: begin
              if (tx_len_q == '0) begin
                ent.fault = mcr_pkg::FLT_NOSIZE;
              end else begin
                tx_we_o   = (tx_fill_q < LEN_W'(BUF_DEPTH));
                tx_fill_d = tx_fill_inc;
                if (tx_fill_inc >= tx_len_q) begin
                  // message complete: hand the whole run to the back end
                  flush_pend_d = 1'b1;
                  ent.kind     = mcr_pkg::KIND_TX;
                  ent.count    = mcr_pkg::CNT_W'(tx_len_q);
                  tx_fill_d    = '0;
                  tx_len_d     = '0;
                end
              end
            end
            default: begin
              ent.fault = mcr_pkg::FLT_ADDR;
            end
          endcase
        end
        mcr_pkg::ACT_READ: begin
          ent.kind = mcr_pkg::KIND_READ;
          if (item_i.addr >= mcr_pkg::ADDR_RX_BASE) begin
            if (rx_off < 8'(BUF_DEPTH)) begin
              rx_re  = 1'b1;
              rx_hit = rx_vld_q[rx_off[AW-1:0]];
            end else begin
              ent.fault = mcr_pkg::FLT_ADDR;
            end
          end else begin
            unique case (item_i.addr) inside
              mcr_pkg::ADDR_STATUS: begin
                ent.rdata = 32'(rdy_q);
                rdy_d     = 1'b0;
              end
              mcr_pkg::ADDR_RXSIZE: begin
                ent.rdata = 32'(rx_len_q);
              end
              mcr_pkg::ADDR_CTRL, mcr_pkg::ADDR_TXSIZE, mcr_pkg::ADDR_TXDATA: begin
                ent.rdata = '0;
              end
              default: begin
                ent.fault = mcr_pkg::FLT_ADDR;
              end
            endcase
          end
        end
        mcr_pkg::ACT_HOST: begin
          if (di_q) begin
            if (item_i.host_last) begin
              rx_fill_d = '0;
            end
          end else begin
            if (rx_fill_q < LEN_W'(BUF_DEPTH)) begin
              rx_we                        = 1'b1;
              rx_vld_d[rx_fill_q[AW-1:0]]  = 1'b1;
              rx_fill_d                    = rx_fill_q + LEN_W'(1);
            end else begin
              ent.fault = mcr_pkg::FLT_OVFL;
            end
            if (item_i.host_last) begin
              rx_len_d  = rx_fill_d;
              rx_fill_d = '0;
              rdy_d     = 1'b1;
              irq_d     = 1'b1;
            end
          end
        end
        default: begin
          ent.kind = mcr_pkg::KIND_ACK;
        end
      endcase
    end

    ent.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      di_q         <= 1'b0;
      rdy_q        <= 1'b0;
      irq_q        <= 1'b0;
      tx_len_q     <= '0;
      tx_fill_q    <= '0;
      rx_len_q     <= '0;
      rx_fill_q    <= '0;
      rx_vld_q     <= '0;
      flush_pend_q <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      di_q         <= di_d;
      rdy_q        <= rdy_d;
      irq_q        <= irq_d;
      tx_len_q     <= tx_len_d;
      tx_fill_q    <= tx_fill_d;
      rx_len_q     <= rx_len_d;
      rx_fill_q    <= rx_fill_d;
      rx_vld_q     <= rx_vld_d;
      flush_pend_q <= flush_pend_d;
      if (s1_adv) begin
        s1_valid_q <= take;
      end
    end
  end

  // stage one waits for the registered receive buffer read
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q    <= ent;
      s1_rx_q <= rx_hit;
    end
  end

  mcr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_fill_q[AW-1:0]),
    .wdata_i (item_i.host_byte),
    .re_i    (rx_re),
    .raddr_i (rx_off[AW-1:0]),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    cmd_o = s1_q;
    if (s1_rx_q) begin
      cmd_o.rdata = 32'(rx_rdata);
    end
  end

  assign cmd_push_o = s1_valid_q && !cmd_full_i;

endmodule

// ===== sv/mcr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// mcr_cmd_fifo
// Two-entry command queue between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
module mcr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mcr_pkg::cmd_t data_o,
  output logic          empty_o
);

  mcr_pkg::cmd_t entry_q [2];
  logic          wptr_q;
  logic          rptr_q;
  logic [1:0]    cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Result sequencer: single results and transmit message read-out.
// ----------------------------------------------------------------------------
module mcr_back #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cmd_empty_i,
  input  mcr_pkg::cmd_t                             cmd_i,
  output logic                                      cmd_pop_o,
  output logic                                      tx_re_o,
  output logic [mcr_pkg::addr_width(BUF_DEPTH)-1:0] tx_raddr_o,
  input  logic [7:0]                                tx_rdata_i,
  output logic                                      flush_done_o,
  output logic                                      empty,
  input  logic                                      pop,
  output mcr_pkg::out_item_t                        out_o
);

  localparam int unsigned LEN_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned AW    = mcr_pkg::addr_width(BUF_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } bk_state_e;

  bk_state_e          st_q, st_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0]   n_q, n_d;
  logic               irq_q, irq_d;
  logic               out_valid_q, out_valid_d;
  mcr_pkg::out_item_t out_q, out_d;
  logic               out_free;

  assign out_free = !out_valid_q || pop;

  always_comb begin
    st_d         = st_q;
    idx_d        = idx_q;
    n_d          = n_q;
    irq_d        = irq_q;
    out_valid_d  = out_valid_q && !pop;
    out_d        = out_q;
    cmd_pop_o    = 1'b0;
    tx_re_o      = 1'b0;
    tx_raddr_o   = idx_q[AW-1:0];
    flush_done_o = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.kind == mcr_pkg::KIND_TX) begin
            cmd_pop_o  = 1'b1;
            n_d        = cmd_i.count[LEN_W-1:0];
            irq_d      = cmd_i.irq;
            tx_re_o    = 1'b1;
            tx_raddr_o = '0;
            idx_d      = LEN_W'(1);
            st_d       = ST_FLUSH;
          end else if (out_free) begin
            cmd_pop_o       = 1'b1;
            out_valid_d     = 1'b1;
            out_d.kind      = cmd_i.kind;
            out_d.rdata     = cmd_i.rdata;
            out_d.tx_byte   = '0;
            out_d.tx_last   = 1'b0;
            out_d.irq_level = cmd_i.irq;
            out_d.fault     = cmd_i.fault;
          end
        end
      end
      ST_FLUSH: begin
        // byte idx_q-1 sits in the memory output register
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mcr_pkg::KIND_TX;
          out_d.rdata     = '0;
          out_d.tx_byte   = tx_rdata_i;
          out_d.tx_last   = (idx_q == n_q);
          out_d.irq_level = irq_q;
          out_d.fault     = mcr_pkg::FLT_OK;
          if (idx_q == n_q) begin
            flush_done_o = 1'b1;
            st_d         = ST_IDLE;
          end else begin
            tx_re_o = 1'b1;
            idx_d   = idx_q + LEN_W'(1);
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty = !out_valid_q;
  assign out_o = out_q;

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == ST_IDLE)
    else $error("command taken during message read-out");

  a_flush_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_FLUSH |-> (idx_q != '0) && (idx_q <= n_q))
    else $error("read-out index out of range");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_done_o |=> st_q == ST_IDLE)
    else $error("read-out did not end after last byte");

  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tx_last |-> out_q.kind == mcr_pkg::KIND_TX)
    else $error("last mark on a non-transmit result");
`endif

endmodule
